### design/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants and types of the PID speed controller: default widths,
// configuration register indexes, the reset value of the upper drive limit,
// and the mode flags.
package psc_pkg;

    // default data path widths
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // configuration register index
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ACTION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE      = 3'd6;

    // reset value of the upper drive limit
    localparam int OUT_MAX_RESET = 1023;

    // loop mode flags
    typedef struct packed {
        logic reverse_action;
        logic auto_mode;
    } t_mode;

endpackage

### design/psc_cfg_regs.sv
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Configuration register file: gains, drive limits and mode flags, written
// through a valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module psc_cfg_regs
    import psc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data,
    output logic signed [DATA_WIDTH-1:0] o_kp_gain,
    output logic signed [DATA_WIDTH-1:0] o_ki_gain,
    output logic signed [DATA_WIDTH-1:0] o_kd_gain,
    output logic signed [DATA_WIDTH-1:0] o_out_min,
    output logic signed [DATA_WIDTH-1:0] o_out_max,
    output t_mode                        o_mode
);

    logic signed [DATA_WIDTH-1:0] r_kp_gain;
    logic signed [DATA_WIDTH-1:0] r_ki_gain;
    logic signed [DATA_WIDTH-1:0] r_kd_gain;
    logic signed [DATA_WIDTH-1:0] r_out_min;
    logic signed [DATA_WIDTH-1:0] r_out_max;
    t_mode                        r_mode;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_gain <= '0;
            r_ki_gain <= '0;
            r_kd_gain <= '0;
            r_out_min <= '0;
            r_out_max <= DATA_WIDTH'(OUT_MAX_RESET);
            r_mode    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KP_GAIN:        r_kp_gain <= $signed(i_cfg_data);
                REG_KI_GAIN:        r_ki_gain <= $signed(i_cfg_data);
                REG_KD_GAIN:        r_kd_gain <= $signed(i_cfg_data);
                REG_OUT_MIN:        r_out_min <= $signed(i_cfg_data);
                REG_OUT_MAX:        r_out_max <= $signed(i_cfg_data);
                REG_REVERSE_ACTION: r_mode.reverse_action <= i_cfg_data[0];
                REG_AUTO_MODE:      r_mode.auto_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_kp_gain = r_kp_gain;
    assign o_ki_gain = r_ki_gain;
    assign o_kd_gain = r_kd_gain;
    assign o_out_min = r_out_min;
    assign o_out_max = r_out_max;
    assign o_mode    = r_mode;

endmodule

### design/psc_datapath.sv
// ----------------------------------------------------------------------------
// psc_datapath
// One PID update: restart preload, integral accumulate and clamp, drive sum
// with derivative on measurement, clamp, truncation toward zero and manual hold.
// ----------------------------------------------------------------------------
module psc_datapath
    import psc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic signed [DATA_WIDTH-1:0]           i_kp_gain,
    input  logic signed [DATA_WIDTH-1:0]           i_ki_gain,
    input  logic signed [DATA_WIDTH-1:0]           i_kd_gain,
    input  logic signed [DATA_WIDTH-1:0]           i_out_min,
    input  logic signed [DATA_WIDTH-1:0]           i_out_max,
    input  t_mode                                  i_mode,
    input  logic signed [DATA_WIDTH+FRAC_BITS-1:0] i_integral,
    input  logic [DATA_WIDTH-1:0]                  i_last_measured,
    input  logic signed [DATA_WIDTH-1:0]           i_last_drive,
    input  logic [DATA_WIDTH-1:0]                  i_measured,
    input  logic [DATA_WIDTH-1:0]                  i_target,
    input  logic                                   i_restart,
    output logic signed [DATA_WIDTH+FRAC_BITS-1:0] o_integral,
    output logic [DATA_WIDTH-1:0]                  o_last_measured,
    output logic signed [DATA_WIDTH-1:0]           o_last_drive,
    output logic signed [DATA_WIDTH-1:0]           o_drive,
    output logic                                   o_computed
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int IW = W + F;                       // integral and drive, fixed point
    localparam int GW = W + 1;                       // negated gain, error, change
    localparam int PW = 2 * GW;                      // exact product
    localparam int SW = ((PW > IW) ? PW : IW) + 2;   // exact sum
    localparam int CW = (SW > 65) ? SW : 65;         // room for the 64-bit bounds

    localparam logic signed [CW-1:0] SAT_MAX = CW'({1'b0, {63{1'b1}}});
    localparam logic signed [CW-1:0] SAT_MIN = -SAT_MAX - CW'(1);
    localparam logic [IW-1:0]        FMASK   = IW'((64'd1 << F) - 64'd1);

    // saturate at the signed 64-bit range
    function automatic logic signed [CW-1:0] f_sat(input logic signed [CW-1:0] x);
        logic signed [CW-1:0] y;
        if (x > SAT_MAX) begin
            y = SAT_MAX;
        end else if (x < SAT_MIN) begin
            y = SAT_MIN;
        end else begin
            y = x;
        end
        return y;
    endfunction

    // clamp to the limits, upper limit tested first
    function automatic logic signed [IW-1:0] f_limit(
        input logic signed [CW-1:0] x,
        input logic signed [IW-1:0] hi,
        input logic signed [IW-1:0] lo
    );
        logic signed [IW-1:0] y;
        if (x > CW'(hi)) begin
            y = hi;
        end else if (x < CW'(lo)) begin
            y = lo;
        end else begin
            y = IW'(x);
        end
        return y;
    endfunction

    logic signed [IW-1:0] lim_hi;
    logic signed [IW-1:0] lim_lo;
    logic signed [IW-1:0] drive_scaled;
    logic signed [IW-1:0] int_src;
    logic [W-1:0]         meas_src;
    logic signed [GW-1:0] kp_x;
    logic signed [GW-1:0] ki_x;
    logic signed [GW-1:0] kd_x;
    logic signed [GW-1:0] kp_eff;
    logic signed [GW-1:0] ki_eff;
    logic signed [GW-1:0] kd_eff;
    logic signed [GW-1:0] err;
    logic signed [GW-1:0] dmeas;
    logic signed [PW-1:0] p_kp;
    logic signed [PW-1:0] p_ki;
    logic signed [PW-1:0] p_kd;
    logic signed [CW-1:0] int_acc;
    logic signed [IW-1:0] int_new;
    logic signed [CW-1:0] sum_a;
    logic signed [CW-1:0] sum_b;
    logic signed [IW-1:0] drv_fix;
    logic signed [IW-1:0] drv_quot;
    logic                 drv_round;
    logic signed [IW-1:0] drv_int;
    logic signed [W-1:0]  drv_new;

    // limits in fixed point
    assign lim_hi = IW'(i_out_max) <<< F;
    assign lim_lo = IW'(i_out_min) <<< F;

    // restart preload
    assign drive_scaled = IW'(i_last_drive) <<< F;
    assign int_src  = i_restart ? f_limit(CW'(drive_scaled), lim_hi, lim_lo) : i_integral;
    assign meas_src = i_restart ? i_measured : i_last_measured;

    // loop direction
    assign kp_x   = GW'(i_kp_gain);
    assign ki_x   = GW'(i_ki_gain);
    assign kd_x   = GW'(i_kd_gain);
    assign kp_eff = i_mode.reverse_action ? -kp_x : kp_x;
    assign ki_eff = i_mode.reverse_action ? -ki_x : ki_x;
    assign kd_eff = i_mode.reverse_action ? -kd_x : kd_x;

    // error and measurement change
    assign err   = $signed({1'b0, i_target}) - $signed({1'b0, i_measured});
    assign dmeas = $signed({1'b0, i_measured}) - $signed({1'b0, meas_src});

    // gain products
    assign p_kp = kp_eff * err;
    assign p_ki = ki_eff * err;
    assign p_kd = kd_eff * dmeas;

    // integral update
    assign int_acc = f_sat(CW'(int_src) + CW'(p_ki));
    assign int_new = f_limit(int_acc, lim_hi, lim_lo);

    // drive sum and clamp
    assign sum_a   = f_sat(CW'(p_kp) + CW'(int_new));
    assign sum_b   = f_sat(sum_a - CW'(p_kd));
    assign drv_fix = f_limit(sum_b, lim_hi, lim_lo);

    // drop the fraction toward zero
    assign drv_quot  = drv_fix >>> F;
    assign drv_round = drv_fix[IW-1] && ((drv_fix & FMASK) != '0);
    assign drv_int   = drv_quot + $signed({{(IW-1){1'b0}}, drv_round});
    assign drv_new   = drv_int[W-1:0];

    // manual mode holds drive; integral keeps its value or its restart preload
    always_comb begin
        if (i_mode.auto_mode) begin
            o_integral      = int_new;
            o_last_measured = i_measured;
            o_last_drive    = drv_new;
            o_drive         = drv_new;
            o_computed      = 1'b1;
        end else begin
            o_integral      = int_src;
            o_last_measured = meas_src;
            o_last_drive    = i_last_drive;
            o_drive         = i_last_drive;
            o_computed      = 1'b0;
        end
    end

endmodule

### design/pid_speed_controller_unit.sv
// ----------------------------------------------------------------------------
// pid_speed_controller_unit
// PID speed loop with derivative on measurement and clamped integral.
// ----------------------------------------------------------------------------
// One sample enters per cycle while the output is not stalled. Its result is
// presented after the input register and then the result register, and the
// loop that updates the integral, last measurement and last drive between
// the input and result registers is combinational, so a new sample can
// enter while the result of the last one waits in the result register.
// Each sample gives exactly one result: the clamped drive and a flag that is
// 1 when the loop ran in automatic mode and 0 when the last drive was held.
// Configuration writes are always ready and take effect on the next sample;
// write them only while no sample is in flight.
module pid_speed_controller_unit
    import psc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data,
    // sample input
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [DATA_WIDTH-1:0]        i_measured,
    input  logic [DATA_WIDTH-1:0]        i_target,
    input  logic                         i_restart,
    // result output
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_drive,
    output logic                         o_computed
);

    localparam int IW = DATA_WIDTH + FRAC_BITS;

    logic signed [DATA_WIDTH-1:0] kp_gain;
    logic signed [DATA_WIDTH-1:0] ki_gain;
    logic signed [DATA_WIDTH-1:0] kd_gain;
    logic signed [DATA_WIDTH-1:0] out_min;
    logic signed [DATA_WIDTH-1:0] out_max;
    t_mode                        mode;

    logic                         r_in_valid;
    logic [DATA_WIDTH-1:0]        r_measured;
    logic [DATA_WIDTH-1:0]        r_target;
    logic                         r_restart;

    logic signed [IW-1:0]         r_integral;
    logic [DATA_WIDTH-1:0]        r_last_measured;
    logic signed [DATA_WIDTH-1:0] r_last_drive;
    logic signed [IW-1:0]         n_integral;
    logic [DATA_WIDTH-1:0]        n_last_measured;
    logic signed [DATA_WIDTH-1:0] n_last_drive;

    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_drive;
    logic                         r_computed;
    logic signed [DATA_WIDTH-1:0] n_drive;
    logic                         n_computed;

    logic                         out_adv;
    logic                         in_adv;
    logic                         fire;
    logic                         in_xfer;

    // configuration registers
    psc_cfg_regs #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_kp_gain   (kp_gain),
        .o_ki_gain   (ki_gain),
        .o_kd_gain   (kd_gain),
        .o_out_min   (out_min),
        .o_out_max   (out_max),
        .o_mode      (mode)
    );

    // pipeline flow control
    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign fire    = r_in_valid && out_adv;
    assign o_stall = !in_adv;
    assign in_xfer = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_measured <= i_measured;
            r_target   <= i_target;
            r_restart  <= i_restart;
        end
    end

    // single-pass update
    psc_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_kp_gain       (kp_gain),
        .i_ki_gain       (ki_gain),
        .i_kd_gain       (kd_gain),
        .i_out_min       (out_min),
        .i_out_max       (out_max),
        .i_mode          (mode),
        .i_integral      (r_integral),
        .i_last_measured (r_last_measured),
        .i_last_drive    (r_last_drive),
        .i_measured      (r_measured),
        .i_target        (r_target),
        .i_restart       (r_restart),
        .o_integral      (n_integral),
        .o_last_measured (n_last_measured),
        .o_last_drive    (n_last_drive),
        .o_drive         (n_drive),
        .o_computed      (n_computed)
    );

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral      <= '0;
            r_last_measured <= '0;
            r_last_drive    <= '0;
        end else if (fire) begin
            r_integral      <= n_integral;
            r_last_measured <= n_last_measured;
            r_last_drive    <= n_last_drive;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_drive    <= n_drive;
            r_computed <= n_computed;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_drive    = r_drive;
    assign o_computed = r_computed;

endmodule

### design/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the PID speed controller, bound to the top level.
// ----------------------------------------------------------------------------
module psc_checker
    import psc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [DATA_WIDTH-1:0] o_drive,
    input logic                         o_computed
);

    logic signed [DATA_WIDTH-1:0] r_prev_drive;

    // drive of the most recent result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_drive <= '0;
        end else if (o_valid && !i_stall) begin
            r_prev_drive <= o_drive;
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_drive) && $stable(o_computed)))
        else $error("stalled result changed");

    // input stalls only behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without backpressure");

    // manual results repeat the previous drive
    a_manual_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_computed) |-> (o_drive == r_prev_drive))
        else $error("manual result does not hold last drive");

endmodule

bind pid_speed_controller_unit psc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_psc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_drive    (o_drive),
    .o_computed (o_computed)
);
